>>> rtl/upc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upc_pkg
// Types, constants and helper functions shared by the percent codec modules.
// ---------------------------------------------------------------------------
package upc_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_WIDTH      = 2;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int MAX_BEATS           = 3;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_MODE = 2'd0;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] HEX_ALPHA    = 8'd10;

   typedef enum logic [2:0] {
      PH_PLAIN  = 3'b001,
      PH_FIRST  = 3'b010,
      PH_SECOND = 3'b100
   } upc_phase_type;

   typedef struct packed {
      logic [MAX_BEATS-1:0][7:0] data;
      logic [1:0]                count;
      logic                      byte_valid;
      logic                      last;
   } upc_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } upc_qstat_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] w;
      w = {4'd0, v};
      return (v > 4'd9) ? (w - HEX_ALPHA + CHAR_UPPER_A) : (w + CHAR_ZERO);
   endfunction

   function automatic logic [7:0] hex_value(input logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) ? (c - CHAR_ZERO)
                                                 : (c - CHAR_UPPER_A + HEX_ALPHA);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_ZERO && c <= CHAR_NINE);
   endfunction

endpackage

>>> rtl/url_percent_codec.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// url_percent_codec
// Streaming URL percent encoder and decoder.
// ---------------------------------------------------------------------------
// Usage: message bytes enter on the req channel (req_in_byte, req_last_byte)
// one beat at a time; result beats leave on the rsp channel, one byte each
// with byte_valid, end_of_run and end_of_message flags. The mode register at
// csr address 0 selects encode (0) or decode (1); write it only while idle.
// A beat is taken when valid is high and stall is low.
// Path: an item taken on the req channel that gives result beats is written
// into the queue and then into the output register that drives rsp_valid.
// Throughput: one input beat per cycle while req_stall is low, for items that
// give one result beat; an encoded escape gives three beats, so the rsp port
// (one beat a cycle while rsp_stall is low) sets the sustained rate. A queue
// of QUEUE_DEPTH items lets the input side keep going meanwhile.
// Reset: synchronous; clears the mode to encode, the codec state, the queue
// pointers and count, and the output valid flag and beat index.
// Stall: while rsp_stall is high the output beat holds; once the queue fills,
// req_stall rises until the back side drains an item.
// ---------------------------------------------------------------------------
module url_percent_codec #(
   parameter int QUEUE_DEPTH = upc_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_in_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_byte_valid,
   output logic                                rsp_end_of_run,
   output logic                                rsp_end_of_message,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [upc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [upc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [upc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import upc_pkg::*;

   logic          mode_ff;
   logic          push, pop;
   upc_entry_type push_entry, head;
   upc_qstat_type qstat;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_MODE) ?
                       {{(CSR_DATA_WIDTH-1){1'b0}}, mode_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == CSR_ADDR_MODE) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   upc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .mode          (mode_ff),
      .req_valid     (req_valid),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .qstat         (qstat),
      .req_stall     (req_stall),
      .push          (push),
      .push_entry    (push_entry)
   );

   upc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   upc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .qstat              (qstat),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_end_of_message (rsp_end_of_message)
   );

`ifndef NO_ASSERTIONS
   a_eom_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_message |-> rsp_end_of_run)
      else $error("end of message beat without end of run");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |->
         rsp_out_byte == 8'd0 && rsp_end_of_message)
      else $error("bare marker beat is malformed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output beat present after reset");
`endif

endmodule

>>> rtl/upc_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upc_front
// Accepts input beats, classifies each byte and tracks the codec state,
// queueing the bytes each item produces.
// ---------------------------------------------------------------------------
module upc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   mode,
   input  logic                   req_valid,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_last_byte,
   input  upc_pkg::upc_qstat_type qstat,
   output logic                   req_stall,
   output logic                   push,
   output upc_pkg::upc_entry_type push_entry
);
   import upc_pkg::*;

   upc_phase_type phase_ff, phase_in;
   logic [3:0]    nibble_ff, nibble_in;
   logic          stopped_ff, stopped_in;
   logic          accept;
   logic [7:0]    hv;
   logic [1:0]    count;
   logic [MAX_BEATS-1:0][7:0] data;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;
   assign hv        = hex_value(req_in_byte);

   always_comb begin
      phase_in   = phase_ff;
      nibble_in  = nibble_ff;
      stopped_in = stopped_ff;
      count      = 2'd0;
      data       = '0;
      if (mode == MODE_ENCODE) begin
         if (!stopped_ff) begin
            if (req_in_byte == 8'd0) begin
               stopped_in = 1'b1;
            end else if (is_alnum(req_in_byte)) begin
               count   = 2'd1;
               data[0] = req_in_byte;
            end else begin
               count   = 2'd3;
               data[0] = CHAR_PERCENT;
               data[1] = hex_digit(req_in_byte[7:4]);
               data[2] = hex_digit(req_in_byte[3:0]);
            end
         end
      end else begin
         unique case (phase_ff)
            PH_FIRST: begin
               nibble_in = hv[3:0];
               phase_in  = PH_SECOND;
            end
            PH_SECOND: begin
               count    = 2'd1;
               data[0]  = {nibble_ff, 4'd0} | hv;
               phase_in = PH_PLAIN;
            end
            default: begin
               phase_in = PH_PLAIN;
               if (req_in_byte == CHAR_PERCENT) begin
                  phase_in = PH_FIRST;
               end else if (req_in_byte == CHAR_PLUS) begin
                  count   = 2'd1;
                  data[0] = CHAR_SPACE;
               end else begin
                  count   = 2'd1;
                  data[0] = req_in_byte;
               end
            end
         endcase
      end
      if (req_last_byte) begin
         phase_in   = PH_PLAIN;
         nibble_in  = 4'd0;
         stopped_in = 1'b0;
      end
   end

   always_comb begin
      push_entry.data       = data;
      push_entry.count      = (count == 2'd0) ? 2'd1 : count;
      push_entry.byte_valid = (count != 2'd0);
      push_entry.last       = req_last_byte;
      push                  = accept && ((count != 2'd0) || req_last_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_PLAIN;
         nibble_ff  <= 4'd0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         nibble_ff  <= nibble_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

>>> rtl/upc_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upc_queue
// Short queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module upc_queue #(
   parameter int DEPTH = upc_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  upc_pkg::upc_entry_type push_entry,
   input  logic                   pop,
   output upc_pkg::upc_entry_type head,
   output upc_pkg::upc_qstat_type qstat
);
   import upc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   upc_entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/upc_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upc_back
// Walks head item bytes to output register one beat a cycle unless stalled.
// ---------------------------------------------------------------------------
module upc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  upc_pkg::upc_entry_type head,
   input  upc_pkg::upc_qstat_type qstat,
   output logic                   pop,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic                   rsp_end_of_run,
   output logic                   rsp_end_of_message
);
   import upc_pkg::*;

   logic       valid_ff;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff;
   logic       bvalid_ff, eor_ff, eom_ff;
   logic       load, final_beat;

   assign load       = !qstat.empty && (!valid_ff || !rsp_stall);
   assign final_beat = (idx_ff == head.count - 2'd1);
   assign pop        = load && final_beat;
   assign idx_in     = final_beat ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= head.data[idx_ff];
         bvalid_ff <= head.byte_valid;
         eor_ff    <= final_beat;
         eom_ff    <= final_beat && head.last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_byte_valid     = bvalid_ff;
   assign rsp_end_of_run     = eor_ff;
   assign rsp_end_of_message = eom_ff;

endmodule

>>> tb/url_percent_codec_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// url_percent_codec_tb
// Self-checking bench for the streaming URL percent encoder and decoder.
// A scoreboard predicts the result beats of every message byte taken on the
// req channel and checks them in order against the rsp channel. A directed
// pass covers letters, digits, escapes, zero bytes and truncated escapes.
// Random phases follow; decode phases mix escape sequences, plus signs, word
// characters and noise, and the mode is set before each phase, often in the
// middle of a message. Both channels idle and stall at random. One phase
// holds the rsp channel off long enough to back up the input side.
// ---------------------------------------------------------------------------
module url_percent_codec_tb;
   import upc_pkg::*;

   localparam int NUM_ITEMS   = 480;
   localparam int IDLE_LIMIT  = 1000;
   localparam int SETTLE_CYC  = 12;
   localparam int HOLD_CYC    = 150;

   typedef struct packed {
      logic [7:0] data;
      logic       byte_valid;
      logic       end_of_run;
      logic       end_of_message;
   } codec_beat_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } msg_char_type;

   class percent_codec_scoreboard;
      logic            mode;
      upc_phase_type   dec_phase;
      logic [3:0]      hi_nibble;
      logic            enc_stopped;
      codec_beat_type  expected_beats[$];
      int              errors;

      function new();
         mode        = MODE_ENCODE;
         dec_phase   = PH_PLAIN;
         hi_nibble   = 4'd0;
         enc_stopped = 1'b0;
         errors      = 0;
      endfunction

      function void set_mode(logic m);
         mode = m;
      endfunction

      function int beats_due();
         return expected_beats.size();
      endfunction

      function logic [7:0] nibble_char(logic [3:0] v);
         if (v > 4'd9)
            return CHAR_UPPER_A + {4'd0, v} - 8'd10;
         return CHAR_ZERO + {4'd0, v};
      endfunction

      function logic [7:0] char_value(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return c - CHAR_ZERO;
         return c - CHAR_UPPER_A + 8'd10;
      endfunction

      function logic word_char(logic [7:0] c);
         return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
                (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
                (c >= CHAR_ZERO && c <= CHAR_NINE);
      endfunction

      function void take_char(logic [7:0] c, logic last);
         codec_beat_type run[$];
         logic [7:0]     cv;
         if (mode == MODE_ENCODE) begin
            if (!enc_stopped) begin
               if (c == 8'd0) begin
                  enc_stopped = 1'b1;
               end else if (word_char(c)) begin
                  run.push_back(codec_beat_type'{c, 1'b1, 1'b0, 1'b0});
               end else begin
                  run.push_back(codec_beat_type'{CHAR_PERCENT, 1'b1, 1'b0, 1'b0});
                  run.push_back(codec_beat_type'{nibble_char(c[7:4]), 1'b1, 1'b0, 1'b0});
                  run.push_back(codec_beat_type'{nibble_char(c[3:0]), 1'b1, 1'b0, 1'b0});
               end
            end
         end else begin
            case (dec_phase)
               PH_FIRST: begin
                  cv        = char_value(c);
                  hi_nibble = cv[3:0];
                  dec_phase = PH_SECOND;
               end
               PH_SECOND: begin
                  run.push_back(codec_beat_type'{{hi_nibble, 4'd0} | char_value(c),
                                                 1'b1, 1'b0, 1'b0});
                  dec_phase = PH_PLAIN;
               end
               default: begin
                  dec_phase = PH_PLAIN;
                  if (c == CHAR_PERCENT)
                     dec_phase = PH_FIRST;
                  else if (c == CHAR_PLUS)
                     run.push_back(codec_beat_type'{CHAR_SPACE, 1'b1, 1'b0, 1'b0});
                  else
                     run.push_back(codec_beat_type'{c, 1'b1, 1'b0, 1'b0});
               end
            endcase
         end
         if (last) begin
            if (run.size() == 0)
               run.push_back(codec_beat_type'{8'd0, 1'b0, 1'b0, 1'b0});
            run[run.size()-1].end_of_message = 1'b1;
            dec_phase   = PH_PLAIN;
            hi_nibble   = 4'd0;
            enc_stopped = 1'b0;
         end
         if (run.size() > 0)
            run[run.size()-1].end_of_run = 1'b1;
         foreach (run[i])
            expected_beats.push_back(run[i]);
      endfunction

      function void report_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_beat(codec_beat_type got);
         codec_beat_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %0h", $time, got);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         report_field("out_byte", int'(want.data), int'(got.data));
         report_field("byte_valid", int'(want.byte_valid), int'(got.byte_valid));
         report_field("end_of_run", int'(want.end_of_run), int'(got.end_of_run));
         report_field("end_of_message", int'(want.end_of_message),
                      int'(got.end_of_message));
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [7:0]                 req_in_byte;
   logic                       req_last_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [7:0]                 rsp_out_byte;
   logic                       rsp_byte_valid;
   logic                       rsp_end_of_run;
   logic                       rsp_end_of_message;
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0]  csr_paddr;
   logic [CSR_DATA_WIDTH-1:0]  csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0]  csr_prdata;
   logic                       csr_pready;

   percent_codec_scoreboard codec_sb = new();
   msg_char_type            msg_chars[$];
   bit                      steady;
   bit                      hold_off;
   int                      chars_sent;
   int                      idle_cycles;

   url_percent_codec u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_end_of_run     (rsp_end_of_run),
      .rsp_end_of_message (rsp_end_of_message),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // result beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         codec_sb.check_beat(codec_beat_type'{rsp_out_byte, rsp_byte_valid,
                                              rsp_end_of_run, rsp_end_of_message});
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver stall pattern
   initial begin
      int   r;
      int   len;
      logic level;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off) begin
            hold_off = 1'b0;
            level    = 1'b1;
            len      = HOLD_CYC;
         end else if (steady) begin
            level = 1'b0;
            len   = 1;
         end else begin
            r = $urandom_range(0, 19);
            if (r < 10) begin
               level = 1'b0;
               len   = $urandom_range(1, 4);
            end else if (r < 17) begin
               level = 1'b1;
               len   = $urandom_range(1, 3);
            end else begin
               level = 1'b1;
               len   = $urandom_range(10, 40);
            end
         end
         rsp_stall <= level;
         repeat (len) @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 19);
      if (r < 12)
         return 0;
      if (r < 18)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_char(input logic [7:0] value, input logic last);
      msg_chars.push_back(msg_char_type'{value, last});
   endtask

   task automatic send_chars();
      msg_char_type item;
      int           gap;
      while (msg_chars.size() > 0) begin
         item = msg_chars.pop_front();
         req_valid     <= 1'b1;
         req_in_byte   <= item.value;
         req_last_byte <= item.last;
         do @(posedge clock); while (!(req_valid && !req_stall));
         codec_sb.take_char(req_in_byte, req_last_byte);
         chars_sent++;
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (codec_sb.beats_due() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_mode(input logic m);
      csr_write(CSR_ADDR_MODE, {{(CSR_DATA_WIDTH-1){1'b0}}, m});
      codec_sb.set_mode(m);
   endtask

   function automatic logic [7:0] rand_hex_char();
      int v;
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom_range(0, 255));
      v = $urandom_range(0, 15);
      if (v < 10)
         return 8'(CHAR_ZERO + v);
      return 8'(CHAR_UPPER_A + v - 10);
   endfunction

   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(0, 2))
         0: return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
         1: return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
         default: return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      endcase
   endfunction

   function automatic logic rand_last();
      return $urandom_range(0, 9) == 0;
   endfunction

   task automatic build_chars(input logic m, input int count);
      int r;
      while (msg_chars.size() < count) begin
         r = $urandom_range(0, 19);
         if (m == MODE_DECODE) begin
            if (r < 8) begin
               add_char(CHAR_PERCENT, rand_last());
               add_char(rand_hex_char(), rand_last());
               add_char(rand_hex_char(), rand_last());
            end else if (r < 11) begin
               add_char(CHAR_PLUS, rand_last());
            end else if (r < 17) begin
               add_char(rand_word_char(), rand_last());
            end else begin
               add_char(8'($urandom_range(0, 255)), rand_last());
            end
         end else begin
            if (r < 10)
               add_char(rand_word_char(), rand_last());
            else if (r < 19)
               add_char(8'($urandom_range(1, 255)), rand_last());
            else
               add_char(8'd0, rand_last());
         end
      end
   endtask

   initial begin
      int   phase_idx;
      logic m;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_byte   = 8'd0;
      req_last_byte = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      steady        = 1'b0;
      hold_off      = 1'b0;
      chars_sent    = 0;
      idle_cycles   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // encode: letters, digits, escapes, zero stop, bare end markers
      set_mode(MODE_ENCODE);
      add_char(8'h41, 1'b0);
      add_char(8'h7A, 1'b0);
      add_char(8'h30, 1'b0);
      add_char(8'h39, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(8'h20, 1'b0);
      add_char(8'h00, 1'b0);
      add_char(8'h61, 1'b0);
      add_char(8'h62, 1'b1);
      add_char(8'h2F, 1'b1);
      add_char(8'h00, 1'b1);
      send_chars();
      drain();

      // decode: plus, escapes, odd hex, passthrough, truncated escapes
      set_mode(MODE_DECODE);
      add_char(CHAR_PLUS, 1'b0);
      add_char(CHAR_PERCENT, 1'b0);
      add_char(8'h34, 1'b0);
      add_char(8'h31, 1'b0);
      add_char(CHAR_PERCENT, 1'b0);
      add_char(8'h7A, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(8'h00, 1'b0);
      add_char(8'hFF, 1'b0);
      add_char(CHAR_PERCENT, 1'b0);
      add_char(8'h34, 1'b1);
      add_char(CHAR_PERCENT, 1'b1);
      add_char(8'h41, 1'b1);
      send_chars();
      drain();

      phase_idx  = 0;
      chars_sent = 0;
      while (chars_sent < NUM_ITEMS) begin
         if (phase_idx < 2)
            m = phase_idx[0];
         else
            m = 1'($urandom_range(0, 1));
         set_mode(m);
         build_chars(m, $urandom_range(20, 60));
         steady = (phase_idx == 2) || ($urandom_range(0, 4) == 0);
         if (phase_idx == 2)
            hold_off = 1'b1;
         send_chars();
         steady = 1'b0;
         drain();
         phase_idx++;
      end

      repeat (20) @(posedge clock);
      if (codec_sb.errors == 0 && codec_sb.beats_due() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
